[hdl/swz_pkg.sv]
`default_nettype none
package swz_pkg;

  localparam int NUM_METRICS       = 5;
  localparam int DEF_WINDOW_DEPTH  = 256;
  localparam int DEF_SAMPLE_BITS   = 24;

  localparam int THR_W  = 16;
  localparam int MIN_W  = 9;
  localparam int ID_W   = 3;
  localparam int Z_W    = 16;   // Q8.8 z-score
  localparam int ZSQ_SH = 16;   // 256^2 scale for the squared ratio
  localparam int QUO_W  = 32;   // quotient bits kept by the divider
  localparam int STEP_W = $clog2(QUO_W);
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [THR_W-1:0] THR_RESET = 16'd768;
  localparam logic [MIN_W-1:0] MIN_RESET = 9'd16;

  localparam logic [ID_W-1:0] NO_METRIC   = 3'd5;
  localparam logic [ID_W-1:0] LAST_METRIC = 3'd4;

  // register index taken from paddr[2]
  localparam logic REG_THR = 1'b0;
  localparam logic REG_MIN = 1'b1;

  // datapath operations
  localparam logic [3:0] OP_IDLE  = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_SQ    = 4'd2;
  localparam logic [3:0] OP_ACC   = 4'd3;
  localparam logic [3:0] OP_WRITE = 4'd4;
  localparam logic [3:0] OP_Z1    = 4'd5;
  localparam logic [3:0] OP_Z2    = 4'd6;
  localparam logic [3:0] OP_Z3    = 4'd7;
  localparam logic [3:0] OP_Z4    = 4'd8;
  localparam logic [3:0] OP_DIVI  = 4'd9;
  localparam logic [3:0] OP_DIVS  = 4'd10;
  localparam logic [3:0] OP_SQS   = 4'd11;
  localparam logic [3:0] OP_ZDONE = 4'd12;
  localparam logic [3:0] OP_MEANI = 4'd13;
  localparam logic [3:0] OP_MEAND = 4'd14;
  localparam logic [3:0] OP_OUT   = 4'd15;

  typedef struct packed {
    logic [3:0]        op;
    logic [ID_W-1:0]   metric;
    logic [STEP_W-1:0] step;
  } swz_cmd_t;

  typedef struct packed {
    logic            eval;
    logic            zskip;
    logic            any_fire;
    logic [ID_W-1:0] fid;
  } swz_stat_t;

endpackage
`default_nettype wire

[hdl/swz_ram.sv]
`default_nettype none
module swz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[hdl/swz_ctrl.sv]
`default_nettype none
module swz_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  output      logic                out_valid,
  input  wire logic                out_stall,
  input  wire swz_pkg::swz_stat_t  status_i,
  output      swz_pkg::swz_cmd_t   cmd_o
);

  localparam int SW_ = swz_pkg::STEP_W;
  localparam logic [SW_-1:0] DIV_LAST = SW_'(swz_pkg::QUO_W - 1);
  localparam logic [SW_-1:0] SQ_LAST  = SW_'(swz_pkg::Z_W - 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SQ    = 5'd1;
  localparam logic [4:0] S_ACC   = 5'd2;
  localparam logic [4:0] S_WRITE = 5'd3;
  localparam logic [4:0] S_EVAL  = 5'd4;
  localparam logic [4:0] S_Z1    = 5'd5;
  localparam logic [4:0] S_Z2    = 5'd6;
  localparam logic [4:0] S_Z3    = 5'd7;
  localparam logic [4:0] S_Z4    = 5'd8;
  localparam logic [4:0] S_DIVI  = 5'd9;
  localparam logic [4:0] S_DIVS  = 5'd10;
  localparam logic [4:0] S_SQS   = 5'd11;
  localparam logic [4:0] S_ZDONE = 5'd12;
  localparam logic [4:0] S_MCHK  = 5'd13;
  localparam logic [4:0] S_MEANI = 5'd14;
  localparam logic [4:0] S_MEANS = 5'd15;
  localparam logic [4:0] S_MEAND = 5'd16;
  localparam logic [4:0] S_OUT   = 5'd17;

  logic [4:0]                   state_r, state_nxt;
  logic [swz_pkg::ID_W-1:0]     metric_r, metric_nxt;
  logic [SW_-1:0]               step_r, step_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_free;
  swz_pkg::swz_cmd_t            cmd;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt  = state_r;
    metric_nxt = metric_r;
    step_nxt   = step_r;
    cmd.op     = swz_pkg::OP_IDLE;
    cmd.metric = metric_r;
    cmd.step   = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = swz_pkg::OP_LOAD;
          metric_nxt = '0;
          state_nxt  = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op    = swz_pkg::OP_SQ;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op = swz_pkg::OP_ACC;
        if (metric_r == swz_pkg::LAST_METRIC) begin
          state_nxt  = S_WRITE;
          metric_nxt = '0;
        end else begin
          state_nxt  = S_SQ;
          metric_nxt = metric_r + 1'b1;
        end
      end
      S_WRITE: begin
        cmd.op    = swz_pkg::OP_WRITE;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = status_i.eval ? S_Z1 : S_OUT;
      end
      S_Z1: begin
        cmd.op    = swz_pkg::OP_Z1;
        state_nxt = S_Z2;
      end
      S_Z2: begin
        cmd.op    = swz_pkg::OP_Z2;
        state_nxt = S_Z3;
      end
      S_Z3: begin
        cmd.op    = swz_pkg::OP_Z3;
        state_nxt = S_Z4;
      end
      S_Z4: begin
        cmd.op    = swz_pkg::OP_Z4;
        state_nxt = status_i.zskip ? S_ZDONE : S_DIVI;
      end
      S_DIVI: begin
        cmd.op    = swz_pkg::OP_DIVI;
        step_nxt  = DIV_LAST;
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        cmd.op = swz_pkg::OP_DIVS;
        if (step_r == '0) begin
          step_nxt  = SQ_LAST;
          state_nxt = S_SQS;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      S_SQS: begin
        cmd.op = swz_pkg::OP_SQS;
        if (step_r == '0) begin
          state_nxt = S_ZDONE;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      S_ZDONE: begin
        cmd.op = swz_pkg::OP_ZDONE;
        if (metric_r == swz_pkg::LAST_METRIC) begin
          state_nxt = S_MCHK;
        end else begin
          metric_nxt = metric_r + 1'b1;
          state_nxt  = S_Z1;
        end
      end
      S_MCHK: begin
        state_nxt = status_i.any_fire ? S_MEANI : S_OUT;
      end
      S_MEANI: begin
        cmd.op     = swz_pkg::OP_MEANI;
        cmd.metric = status_i.fid;
        step_nxt   = DIV_LAST;
        state_nxt  = S_MEANS;
      end
      S_MEANS: begin
        cmd.op = swz_pkg::OP_DIVS;
        if (step_r == '0) begin
          state_nxt = S_MEAND;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      S_MEAND: begin
        cmd.op    = swz_pkg::OP_MEAND;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.metric = status_i.fid;
        if (out_free) begin
          cmd.op    = swz_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = (cmd.op == swz_pkg::OP_OUT) ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      metric_r    <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      metric_r    <= metric_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign cmd_o     = cmd;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_SQ))
    else $error("accepted item did not start the window update");

  a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !out_valid_r) |=> (out_valid_r && state_r == S_IDLE))
    else $error("free output register was not loaded");

  a_metric_range: assert property (@(posedge clk) disable iff (!rst_n)
    (metric_r <= swz_pkg::LAST_METRIC))
    else $error("metric index out of range");

  a_mean_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MEANI) |-> status_i.any_fire)
    else $error("mean pass without a firing metric");

endmodule
`default_nettype wire

[hdl/swz_dp.sv]
`default_nettype none
module swz_dp #(
  parameter int WINDOW_DEPTH = swz_pkg::DEF_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = swz_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire swz_pkg::swz_cmd_t                cmd_i,
  output      swz_pkg::swz_stat_t               status_o,
  input  wire logic [swz_pkg::THR_W-1:0]        z_threshold,
  input  wire logic [swz_pkg::MIN_W-1:0]        min_samples,
  input  wire logic signed [SAMPLE_BITS-1:0]    loss_sample,
  input  wire logic signed [SAMPLE_BITS-1:0]    fitness_sample,
  input  wire logic signed [SAMPLE_BITS-1:0]    entropy_sample,
  input  wire logic signed [SAMPLE_BITS-1:0]    latency_sample,
  input  wire logic signed [SAMPLE_BITS-1:0]    memory_sample,
  output      logic                             evaluated,
  output      logic                             anomaly,
  output      logic [swz_pkg::ID_W-1:0]         alarm_metric,
  output      logic [swz_pkg::NUM_METRICS-1:0]  firing_mask,
  output      logic signed [SAMPLE_BITS-1:0]    anomaly_value,
  output      logic signed [SAMPLE_BITS-1:0]    window_mean,
  output      logic [swz_pkg::Z_W-1:0]          z_score
);

  localparam int NM   = swz_pkg::NUM_METRICS;
  localparam int SW   = SAMPLE_BITS;
  localparam int PW   = $clog2(WINDOW_DEPTH);
  localparam int NW   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUMW = SW + NW;
  localparam int SQW  = 2 * SW + NW - 1;
  localparam int VW   = NW + SQW;
  localparam int NXW  = SW + NW + 1;
  localparam int DW   = SW + NW;
  localparam int DNW  = 2 * DW + NW;
  localparam int AW   = DNW + swz_pkg::ZSQ_SH;
  localparam int BW   = NW + VW;
  localparam int QW   = swz_pkg::QUO_W;
  localparam int AHW  = AW - QW;
  localparam int RW   = (AHW > BW + 1) ? AHW : BW + 1;
  localparam int ZW   = swz_pkg::Z_W;
  localparam int ZBW  = $clog2(ZW);
  localparam int MW   = swz_pkg::MIN_W;
  localparam int ROWW = NM * SW;

  localparam logic [NW-1:0] CNT_FULL = NW'(WINDOW_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(WINDOW_DEPTH - 1);

  // window and accumulators
  logic signed [SW-1:0]   x_r   [NM];
  logic signed [SUMW-1:0] sum_r [NM];
  logic [SQW-1:0]         sq_r  [NM];
  logic [NW-1:0]          cnt_r;
  logic [PW-1:0]          ptr_r;
  logic                   full_w;

  logic [ROWW-1:0]        row_rd, row_wr;
  logic signed [SW-1:0]   old_w [NM];
  logic                   ram_we, ram_re;

  // per-metric selection
  logic signed [SW-1:0]   x_sel, old_sel;
  logic signed [SUMW-1:0] sum_sel;
  logic [SQW-1:0]         sq_sel;
  logic [SUMW-1:0]        sum_abs;

  logic signed [2*SW-1:0] oldp_w, newp_w;
  logic [2*SW-1:0]        oldsq_r, newsq_r;

  // z-score datapath
  logic [VW-1:0]          nq_w, nq_r, v_w, v_r;
  logic [2*SUMW-1:0]      s2_w, s2_r;
  logic signed [NXW-1:0]  nx_w, nx_r, diff_w;
  logic [DW-1:0]          d_r;
  logic [2*DW-1:0]        dd_r;
  logic [BW-1:0]          b_r;
  logic [NW-1:0]          nm1_w;
  logic [DNW-1:0]         ddn_w;
  logic [AW-1:0]          a_r;
  logic [AHW-1:0]         ahi_w;
  logic                   zskip_r;

  // shared divider and root
  logic [RW-1:0]          rem_r, dvs_r, rem_nxt;
  logic [RW:0]            trial_rem;
  logic                   q_bit;
  logic [QW-1:0]          low_r, quo_r;
  logic                   sat_r, neg_r;
  logic [ZW-1:0]          root_r, root_try;
  logic [2*ZW-1:0]        root_sq;
  logic [ZW-1:0]          zval;
  logic [QW:0]            mean_mag;

  // per-item results
  logic                   eval_r;
  logic [NM-1:0]          mask_r;
  logic [swz_pkg::ID_W-1:0] fid_r;
  logic [ZW-1:0]          zrep_r;
  logic signed [SW-1:0]   mean_r;
  logic [NW-1:0]          cnt_nxt;

  // output register
  logic                   o_eval_r, o_anom_r;
  logic [swz_pkg::ID_W-1:0] o_id_r;
  logic [NM-1:0]          o_mask_r;
  logic signed [SW-1:0]   o_val_r, o_mean_r;
  logic [ZW-1:0]          o_z_r;

  assign ram_re = (cmd_i.op == swz_pkg::OP_LOAD);
  assign ram_we = (cmd_i.op == swz_pkg::OP_WRITE);

  swz_ram #(
    .WIDTH(ROWW),
    .DEPTH(WINDOW_DEPTH)
  ) u_win (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ptr_r),
    .wdata(row_wr),
    .re   (ram_re),
    .raddr(ptr_r),
    .rdata(row_rd)
  );

  always_comb begin
    for (int i = 0; i < NM; i++) begin
      old_w[i] = row_rd[i*SW +: SW];
      row_wr[i*SW +: SW] = x_r[i];
    end
  end

  assign full_w  = (cnt_r == CNT_FULL);
  assign cnt_nxt = full_w ? cnt_r : cnt_r + 1'b1;

  assign x_sel   = x_r[cmd_i.metric];
  assign old_sel = old_w[cmd_i.metric];
  assign sum_sel = sum_r[cmd_i.metric];
  assign sq_sel  = sq_r[cmd_i.metric];
  assign sum_abs = sum_sel[SUMW-1] ? SUMW'(-sum_sel) : SUMW'(sum_sel);

  assign oldp_w = old_sel * old_sel;
  assign newp_w = x_sel * x_sel;

  assign nq_w   = cnt_r * sq_sel;
  assign s2_w   = sum_abs * sum_abs;
  assign nx_w   = $signed({1'b0, cnt_r}) * x_sel;
  assign v_w    = nq_r - s2_r[VW-1:0];
  assign diff_w = nx_r - NXW'(sum_sel);
  assign nm1_w  = cnt_r - 1'b1;
  assign ddn_w  = dd_r * nm1_w;
  assign ahi_w  = a_r[AW-1:QW];

  // restoring divide, one quotient bit a cycle
  assign trial_rem = {rem_r, low_r[QW-1]};
  assign q_bit     = (trial_rem >= {1'b0, dvs_r});
  assign rem_nxt   = q_bit ? RW'(trial_rem - {1'b0, dvs_r}) : RW'(trial_rem);

  // integer root, one bit a cycle
  assign root_try = root_r | (ZW'(1) << cmd_i.step[ZBW-1:0]);
  assign root_sq  = root_try * root_try;

  assign zval = zskip_r ? '0 : (sat_r ? '1 : root_r);

  // floor division for a negative sum rounds the magnitude up
  assign mean_mag = {1'b0, quo_r} + (QW+1)'(neg_r && (rem_r != '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ptr_r <= '0;
      for (int i = 0; i < NM; i++) begin
        sum_r[i] <= '0;
        sq_r[i]  <= '0;
      end
    end else begin
      if (cmd_i.op == swz_pkg::OP_ACC) begin
        sum_r[cmd_i.metric] <= sum_sel + SUMW'(x_sel) - (full_w ? SUMW'(old_sel) : '0);
        sq_r[cmd_i.metric]  <= sq_sel + SQW'(newsq_r) - (full_w ? SQW'(oldsq_r) : '0);
      end
      if (cmd_i.op == swz_pkg::OP_WRITE) begin
        cnt_r <= cnt_nxt;
        ptr_r <= (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd_i.op)
      swz_pkg::OP_LOAD: begin
        x_r[0] <= loss_sample;
        x_r[1] <= fitness_sample;
        x_r[2] <= entropy_sample;
        x_r[3] <= latency_sample;
        x_r[4] <= memory_sample;
      end
      swz_pkg::OP_SQ: begin
        oldsq_r <= oldp_w;
        newsq_r <= newp_w;
      end
      swz_pkg::OP_WRITE: begin
        eval_r <= (MW'(cnt_nxt) >= min_samples);
        mask_r <= '0;
        fid_r  <= '0;
        zrep_r <= '0;
      end
      swz_pkg::OP_Z1: begin
        nq_r <= nq_w;
        s2_r <= s2_w;
        nx_r <= nx_w;
      end
      swz_pkg::OP_Z2: begin
        v_r     <= v_w;
        d_r     <= diff_w[NXW-1] ? DW'(-diff_w) : DW'(diff_w);
        zskip_r <= (v_w == '0) || (cnt_r < NW'(2));
      end
      swz_pkg::OP_Z3: begin
        dd_r <= d_r * d_r;
        b_r  <= cnt_r * v_r;
      end
      swz_pkg::OP_Z4: begin
        a_r <= {ddn_w, {swz_pkg::ZSQ_SH{1'b0}}};
      end
      swz_pkg::OP_DIVI: begin
        rem_r  <= RW'(ahi_w);
        dvs_r  <= RW'(b_r);
        low_r  <= a_r[QW-1:0];
        quo_r  <= '0;
        root_r <= '0;
        sat_r  <= (RW'(ahi_w) >= RW'(b_r));
      end
      swz_pkg::OP_MEANI: begin
        rem_r <= '0;
        dvs_r <= RW'(cnt_r);
        low_r <= QW'(sum_abs);
        quo_r <= '0;
        neg_r <= sum_sel[SUMW-1];
      end
      swz_pkg::OP_DIVS: begin
        rem_r <= rem_nxt;
        low_r <= {low_r[QW-2:0], 1'b0};
        quo_r <= {quo_r[QW-2:0], q_bit};
      end
      swz_pkg::OP_SQS: begin
        if (root_sq <= quo_r) begin
          root_r <= root_try;
        end
      end
      swz_pkg::OP_ZDONE: begin
        if (zval >= z_threshold) begin
          mask_r[cmd_i.metric] <= 1'b1;
          fid_r  <= cmd_i.metric;
          zrep_r <= zval;
        end
      end
      swz_pkg::OP_MEAND: begin
        mean_r <= neg_r ? SW'(-mean_mag) : SW'(mean_mag);
      end
      swz_pkg::OP_OUT: begin
        o_eval_r <= eval_r;
        o_anom_r <= eval_r && (mask_r != '0);
        o_mask_r <= eval_r ? mask_r : '0;
        if (eval_r && (mask_r != '0)) begin
          o_id_r   <= fid_r;
          o_val_r  <= x_sel;
          o_mean_r <= mean_r;
          o_z_r    <= zrep_r;
        end else begin
          o_id_r   <= swz_pkg::NO_METRIC;
          o_val_r  <= '0;
          o_mean_r <= '0;
          o_z_r    <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign status_o.eval     = eval_r;
  assign status_o.zskip    = zskip_r;
  assign status_o.any_fire = (mask_r != '0);
  assign status_o.fid      = fid_r;

  assign evaluated     = o_eval_r;
  assign anomaly       = o_anom_r;
  assign alarm_metric  = o_id_r;
  assign firing_mask   = o_mask_r;
  assign anomaly_value = o_val_r;
  assign window_mean   = o_mean_r;
  assign z_score       = o_z_r;

endmodule
`default_nettype wire

[hdl/sliding_window_zscore_anomaly.sv]
`default_nettype none
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+-------------------------------------------
// in_      | input     | in_valid / in_stall | five signed metric samples
// out_     | output    | out_valid/out_stall | evaluated, anomaly, metric, mask, value, mean, z
// config   | APB       | psel/penable/pready | z_threshold (0x0), min_samples (0x4)
//
// Sequence: the window update runs first; with fewer than min_samples held the
//   result then goes to the output register. Else each metric runs four setup
//   steps, the shared one-bit-a-cycle divider (32 steps) and root unit (16
//   steps), plus the compare; zero variance or under two samples skips divider and root.
//   If any metric fires, one mean divide runs for the last firing metric.
// Reset: synchronous, active low; sums, count and ring pointer clear. The
//   window RAM is not cleared; a stored entry is used only after being written.
// Stalls: in_stall is high while an item is in work; a finished result sits
//   in the output register and the next transfer starts the next item.
module sliding_window_zscore_anomaly #(
  parameter int WINDOW_DEPTH = swz_pkg::DEF_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = swz_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]   in_loss_sample,
  input  wire logic signed [SAMPLE_BITS-1:0]   in_fitness_sample,
  input  wire logic signed [SAMPLE_BITS-1:0]   in_entropy_sample,
  input  wire logic signed [SAMPLE_BITS-1:0]   in_latency_sample,
  input  wire logic signed [SAMPLE_BITS-1:0]   in_memory_sample,
  // result channel
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      logic                            out_evaluated,
  output      logic                            out_anomaly,
  output      logic [swz_pkg::ID_W-1:0]        out_alarm_metric,
  output      logic [swz_pkg::NUM_METRICS-1:0] out_firing_mask,
  output      logic signed [SAMPLE_BITS-1:0]   out_anomaly_value,
  output      logic signed [SAMPLE_BITS-1:0]   out_window_mean,
  output      logic [swz_pkg::Z_W-1:0]         out_z_score,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [swz_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [swz_pkg::DATA_W-1:0]      pwdata,
  output      logic [swz_pkg::DATA_W-1:0]      prdata,
  output      logic                            pready
);

  localparam int TW = swz_pkg::THR_W;
  localparam int MW = swz_pkg::MIN_W;
  localparam int DW = swz_pkg::DATA_W;

  logic [TW-1:0] thr_r;
  logic [MW-1:0] min_r;
  logic          cfg_wr;
  logic          reg_sel;

  swz_pkg::swz_cmd_t  cmd;
  swz_pkg::swz_stat_t status;

  // register index is the word address; only bit 2 decodes
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= swz_pkg::THR_RESET;
      min_r <= swz_pkg::MIN_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        swz_pkg::REG_THR: thr_r <= pwdata[TW-1:0];
        swz_pkg::REG_MIN: min_r <= pwdata[MW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      swz_pkg::REG_THR: prdata = DW'(thr_r);
      swz_pkg::REG_MIN: prdata = DW'(min_r);
      default:          prdata = '0;
    endcase
  end

  // sequencer: one step of the update or the z-score math per cycle; waits on a stalled output
  swz_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // window RAM, accumulators, multipliers, shared divide/root, output register
  swz_dp #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_i         (cmd),
    .status_o      (status),
    .z_threshold   (thr_r),
    .min_samples   (min_r),
    .loss_sample   (in_loss_sample),
    .fitness_sample(in_fitness_sample),
    .entropy_sample(in_entropy_sample),
    .latency_sample(in_latency_sample),
    .memory_sample (in_memory_sample),
    .evaluated     (out_evaluated),
    .anomaly       (out_anomaly),
    .alarm_metric  (out_alarm_metric),
    .firing_mask   (out_firing_mask),
    .anomaly_value (out_anomaly_value),
    .window_mean   (out_window_mean),
    .z_score       (out_z_score)
  );

endmodule
`default_nettype wire

[tb/swz_checker.sv]
`timescale 1ns / 1ps
// Watches the sample, result and register ports of the detector, keeps its own
// copy of the windows and running sums, and checks every result transfer.
module swz_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire logic                            in_stall,
  input  wire logic signed [23:0]              in_loss_sample,
  input  wire logic signed [23:0]              in_fitness_sample,
  input  wire logic signed [23:0]              in_entropy_sample,
  input  wire logic signed [23:0]              in_latency_sample,
  input  wire logic signed [23:0]              in_memory_sample,
  input  wire logic                            out_valid,
  input  wire logic                            out_stall,
  input  wire logic                            out_evaluated,
  input  wire logic                            out_anomaly,
  input  wire logic [swz_pkg::ID_W-1:0]        out_alarm_metric,
  input  wire logic [swz_pkg::NUM_METRICS-1:0] out_firing_mask,
  input  wire logic signed [23:0]              out_anomaly_value,
  input  wire logic signed [23:0]              out_window_mean,
  input  wire logic [swz_pkg::Z_W-1:0]         out_z_score,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [swz_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [swz_pkg::DATA_W-1:0]      pwdata,
  input  wire logic                            pready,
  output int                                   fail_count,
  output int                                   pending,
  output int                                   results_seen,
  output int                                   anomalies_seen
);

  localparam int DEPTH = 256;
  localparam int NM    = swz_pkg::NUM_METRICS;

  typedef struct packed {
    logic                     evaluated;
    logic                     anomaly;
    logic [swz_pkg::ID_W-1:0] alarm_metric;
    logic [4:0]               firing_mask;
    logic [23:0]              anomaly_value;
    logic [23:0]              window_mean;
    logic [15:0]              z_score;
  } verdict_t;

  verdict_t                  verdict_q[$];
  logic [swz_pkg::THR_W-1:0] thr;
  logic [swz_pkg::MIN_W-1:0] min_cnt;
  logic signed [23:0]        win [NM][DEPTH];
  logic signed [63:0]        sums [NM];
  logic [63:0]               sq_sums [NM];
  int unsigned               held;
  int unsigned               ptr;

  // floor(256*z) saturated, done exactly on wide integers
  function automatic logic [15:0] zscore_q88(input logic signed [63:0] x, input logic signed [63:0] s,
                                             input logic [63:0] q, input int unsigned n);
    logic signed [63:0] nn, t;
    logic [63:0]        sm, v, d;
    logic [127:0]       a, b;
    int unsigned        lo, hi, mid;
    nn = n;
    sm = (s < 0) ? -s : s;
    v  = 64'(n) * q - sm * sm;
    t  = nn * x - s;
    d  = (t < 0) ? -t : t;
    if (v == 0 || n < 2) return 16'd0;
    a  = 128'(d) * 128'(d) * 128'(65536) * 128'(n - 1);
    b  = 128'(n) * 128'(v);
    lo = 0;
    hi = 65535;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (b * 128'(mid) * 128'(mid) <= a) lo = mid;
      else hi = mid - 1;
    end
    return lo[15:0];
  endfunction

  function automatic logic signed [63:0] mean_floor(input logic signed [63:0] s, input int unsigned n);
    logic signed [63:0] nn;
    nn = n;
    if (s >= 0) return s / nn;
    return -((-s + nn - 1) / nn);
  endfunction

  task automatic absorb_samples(input logic signed [23:0] smp [NM]);
    verdict_t           r;
    logic signed [63:0] x, old;
    logic [15:0]        z;
    int unsigned        slot;
    slot = ptr;
    r = '0;
    r.alarm_metric = swz_pkg::NO_METRIC;
    for (int i = 0; i < NM; i++) begin
      if (held >= DEPTH) begin
        old = win[i][slot];
        sums[i] -= old;
        sq_sums[i] -= old * old;
      end
      x = smp[i];
      win[i][slot] = smp[i];
      sums[i] += x;
      sq_sums[i] += x * x;
    end
    if (held < DEPTH) held++;
    ptr = (slot + 1) % DEPTH;
    r.evaluated = (held >= min_cnt);
    if (r.evaluated) begin
      for (int i = 0; i < NM; i++) begin
        x = smp[i];
        z = zscore_q88(x, sums[i], sq_sums[i], held);
        if (z >= thr) begin
          r.firing_mask[i] = 1'b1;
          r.alarm_metric   = swz_pkg::ID_W'(i);
          r.anomaly_value  = smp[i];
          r.window_mean    = 24'(mean_floor(sums[i], held));
          r.z_score        = z;
        end
      end
    end
    r.anomaly = |r.firing_mask;
    verdict_q.push_back(r);
  endtask

  task automatic check_result();
    verdict_t e;
    if (verdict_q.size() == 0) begin
      $error("result transfer with no sample pending");
      fail_count++;
      return;
    end
    e = verdict_q.pop_front();
    results_seen++;
    if (e.anomaly) anomalies_seen++;
    if (out_evaluated !== e.evaluated) begin
      $error("evaluated: expected %0d, got %0d", e.evaluated, out_evaluated); fail_count++;
    end
    if (out_anomaly !== e.anomaly) begin
      $error("anomaly: expected %0d, got %0d", e.anomaly, out_anomaly); fail_count++;
    end
    if (out_alarm_metric !== e.alarm_metric) begin
      $error("alarm_metric: expected %0d, got %0d", e.alarm_metric, out_alarm_metric);
      fail_count++;
    end
    if (out_firing_mask !== e.firing_mask) begin
      $error("firing_mask: expected %b, got %b", e.firing_mask, out_firing_mask); fail_count++;
    end
    if (out_anomaly_value !== e.anomaly_value) begin
      $error("anomaly_value: expected %0d, got %0d", $signed(e.anomaly_value), out_anomaly_value);
      fail_count++;
    end
    if (out_window_mean !== e.window_mean) begin
      $error("window_mean: expected %0d, got %0d", $signed(e.window_mean), out_window_mean);
      fail_count++;
    end
    if (out_z_score !== e.z_score) begin
      $error("z_score: expected %0d, got %0d", e.z_score, out_z_score); fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    results_seen = 0;
    anomalies_seen = 0;
  end

  always @(posedge clk) begin
    logic signed [23:0] smp [NM];
    if (!rst_n) begin
      thr = swz_pkg::THR_RESET;
      min_cnt = swz_pkg::MIN_RESET;
      held = 0;
      ptr = 0;
      for (int i = 0; i < NM; i++) begin
        sums[i] = '0;
        sq_sums[i] = '0;
      end
      verdict_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == swz_pkg::REG_THR) thr = pwdata[swz_pkg::THR_W-1:0];
        else min_cnt = pwdata[swz_pkg::MIN_W-1:0];
      end
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) begin
        smp[0] = in_loss_sample;
        smp[1] = in_fitness_sample;
        smp[2] = in_entropy_sample;
        smp[3] = in_latency_sample;
        smp[4] = in_memory_sample;
        absorb_samples(smp);
      end
    end
    pending = verdict_q.size();
  end

endmodule

[tb/tb_sliding_window_zscore_anomaly.sv]
`timescale 1ns / 1ps
module tb_sliding_window_zscore_anomaly;

  localparam int NM = swz_pkg::NUM_METRICS;
  localparam int DATA_W = swz_pkg::DATA_W;

  // these leave a wide margin over the worst item
  localparam int SETTLE     = 400;    // quiet time before a register write / at the end
  localparam int HOLD_LEN   = 800;    // long receiver hold-off
  localparam int IDLE_LIMIT = 20000;  // watchdog: cycles with no transfer at all

  logic clk;
  logic rst_n;
  logic in_valid, in_stall;
  logic signed [23:0] in_smp [NM];
  logic out_valid, out_stall;
  logic out_evaluated, out_anomaly;
  logic [swz_pkg::ID_W-1:0] out_alarm_metric;
  logic [NM-1:0] out_firing_mask;
  logic signed [23:0] out_anomaly_value, out_window_mean;
  logic [swz_pkg::Z_W-1:0] out_z_score;
  logic psel, penable, pwrite, pready;
  logic [swz_pkg::ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;

  int fail_count, pending, results_seen, anomalies_seen;
  int items_sent;
  int settings_used;
  bit idle_on;      // random gaps on both sides
  bit hold_req;     // ask the receiver for one long hold-off
  int hold_cnt, stall_burst, idle_cycles;
  logic signed [23:0] base [NM];

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  sliding_window_zscore_anomaly dut (
    .clk, .rst_n,
    .in_valid, .in_stall,
    .in_loss_sample(in_smp[0]), .in_fitness_sample(in_smp[1]),
    .in_entropy_sample(in_smp[2]), .in_latency_sample(in_smp[3]),
    .in_memory_sample(in_smp[4]),
    .out_valid, .out_stall,
    .out_evaluated, .out_anomaly, .out_alarm_metric, .out_firing_mask,
    .out_anomaly_value, .out_window_mean, .out_z_score,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  swz_checker chk (
    .clk, .rst_n,
    .in_valid, .in_stall,
    .in_loss_sample(in_smp[0]), .in_fitness_sample(in_smp[1]),
    .in_entropy_sample(in_smp[2]), .in_latency_sample(in_smp[3]),
    .in_memory_sample(in_smp[4]),
    .out_valid, .out_stall,
    .out_evaluated, .out_anomaly, .out_alarm_metric, .out_firing_mask,
    .out_anomaly_value, .out_window_mean, .out_z_score,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending, .results_seen, .anomalies_seen
  );

  // Receiver: random stall bursts, plus one long hold-off on
  // request so the block backs up and holds in_stall against the sender.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else if (stall_burst > 0) begin
      stall_burst--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_burst = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: any transfer on any port resets the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_sliding_window_zscore_anomaly NOT OK");
      $finish;
    end
  end

  // All stimulus tasks start and end just after a falling edge.
  task automatic send(input logic signed [23:0] smp [NM]);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_smp   = smp;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);   // transfer on this edge
    items_sent++;
    @(negedge clk);
  endtask

  // Register write: setup cycle then access cycle; only while the block is idle.
  task automatic reg_write(input logic regsel, input logic [DATA_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {regsel, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_mode(input logic [swz_pkg::THR_W-1:0] t,
                          input logic [swz_pkg::MIN_W-1:0] m);
    drain();
    reg_write(swz_pkg::REG_THR, DATA_W'(t));
    reg_write(swz_pkg::REG_MIN, DATA_W'(m));
    settings_used++;
    for (int i = 0; i < NM; i++)
      base[i] = 24'($signed($urandom_range(0, 8388607)) - 4194304);
  endtask

  // Mostly samples clustered around a per-metric base, with single-metric
  // spikes and some fully random items so every bit toggles.
  task automatic send_random();
    logic signed [23:0] smp [NM];
    int r;
    r = $urandom_range(0, 99);
    for (int i = 0; i < NM; i++) begin
      if (r >= 90 || $urandom_range(0, 11) == 0)
        smp[i] = 24'($urandom);
      else if (r < 10)
        smp[i] = base[i];                       // flat: zero variance if repeated
      else
        smp[i] = base[i] + 24'($signed($urandom_range(0, 511)) - 256);
    end
    send(smp);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_random();
  endtask

  initial begin
    logic signed [23:0] d [NM];
    rst_n = 1'b0;
    in_valid = 1'b0;
    for (int i = 0; i < NM; i++) in_smp[i] = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    idle_on = 1'b0; hold_req = 1'b0; hold_cnt = 0; stall_burst = 0;
    idle_cycles = 0; items_sent = 0; settings_used = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: evaluate from the very first sample with threshold zero, so
    // a single held sample and flat windows (z = 0) fire every metric.
    set_mode(16'd0, 9'd0);
    d = '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0};
    send(d);
    send(d);
    d = '{24'sd8388607, -24'sd8388608, 24'sd1, -24'sd1, 24'sd0};
    send(d);
    d = '{-24'sd8388608, 24'sd8388607, -24'sd1, 24'sd1, 24'sd0};
    send(d);

    // Directed under the default settings: extremes swinging, two flat metrics,
    // then spikes on the quiet windows.
    set_mode(16'd768, 9'd16);
    for (int k = 0; k < 14; k++) begin
      d[0] = (k % 2) ? -24'sd8388608 : 24'sd8388607;
      d[1] = 24'sd100 + 24'(k % 3);
      d[2] = 24'sd5;
      d[3] = -24'sd7 + 24'(k % 2);
      d[4] = 24'sd0;
      send(d);
    end
    d = '{24'sd0, 24'sd8388607, 24'sd5, -24'sd8388608, 24'sd0};
    send(d);
    d = '{24'sd0, 24'sd101, 24'sd5, 24'sd8388607, 24'sd8388607};
    send(d);

    // Random phases over a spread of settings; the window wraps along the way.
    idle_on = 1'b1;
    set_mode(16'd768, 9'd16);
    run_random(30);
    hold_req = 1'b1;                            // long hold-off while sending on
    run_random(70);
    set_mode(16'd0, 9'd2);
    run_random(40);
    set_mode(16'd65535, 9'd256);
    run_random(60);
    set_mode(16'd128, 9'd1);
    run_random(50);
    set_mode(16'd256, 9'd511);                  // never evaluates
    run_random(25);
    set_mode(16'($urandom), 9'($urandom_range(2, 256)));
    run_random(40);
    set_mode(16'd512, 9'd200);
    run_random(40);

    // Final stretch with no idling on either side.
    set_mode(16'd768, 9'd16);
    idle_on = 1'b0;
    run_random(50);
    drain();

    $display("Sent %0d sample sets over %0d threshold/min_samples settings;", items_sent,
             settings_used);
    $display("checked %0d results, %0d of them flagged anomalous.", results_seen, anomalies_seen);
    if (fail_count == 0 && pending == 0)
      $display("tb_sliding_window_zscore_anomaly OK");
    else
      $display("tb_sliding_window_zscore_anomaly NOT OK");
    $finish;
  end

endmodule
